>>> rtl/assert_macros.svh
// Assertion helpers for the modular ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every edge, off during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mpa_pkg.sv
package mpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_NEG    = 4'd3,
    OP_INCR   = 4'd4,
    OP_DECR   = 4'd5,
    OP_INV    = 4'd6,
    OP_DIV    = 4'd7,
    OP_POW    = 4'd8,
    OP_ADDMUL = 4'd9,
    OP_SUBMUL = 4'd10,
    OP_CMP    = 4'd11
  } op_t;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  localparam int NEWTON_ROUNDS = 7;

endpackage

>>> rtl/mpa_mul.sv
// Shared multiplier: one 32x32 partial product per cycle, summed over the steps
// low x low, low x high, high x low; low WIDTH bits kept.
module mpa_mul
  import mpa_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  output logic             done,
  output logic [WIDTH-1:0] p
);

  localparam int HW = 32;
  localparam int EW = 2 * HW;

  logic [EW-1:0]  xe, ye;
  logic [1:0]     step;
  logic           busy;
  logic [HW-1:0]  xs, ys;
  logic [EW-1:0]  prod;
  logic [EW-1:0]  addend;
  logic [EW-1:0]  acc;

  // step 0: xl*yl, step 1: xl*yh << 32, step 2: xh*yl << 32
  always_comb begin
    xs     = (step == 2'd2) ? xe[EW-1:HW] : xe[HW-1:0];
    ys     = (step == 2'd1) ? ye[EW-1:HW] : ye[HW-1:0];
    prod   = EW'(xs) * EW'(ys);
    addend = (step == 2'd0) ? prod : {prod[HW-1:0], {HW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        xe   <= EW'(x);
        ye   <= EW'(y);
        acc  <= '0;
      end else if (busy) begin
        acc  <= acc + addend;
        step <= step + 2'd1;
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign p = acc[WIDTH-1:0];

endmodule

>>> rtl/mpa_core.sv
// Sequencer around the shared multiplier.
module mpa_core
  import mpa_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [3:0]       op,
  input  logic [WIDTH-1:0] mask,
  input  logic [WIDTH-1:0] a_in,
  input  logic [WIDTH-1:0] b_in,
  input  logic [WIDTH-1:0] acc_in,
  input  logic [63:0]      e_in,
  output logic             done,
  output logic [WIDTH-1:0] res,
  output logic             res_ok,
  output logic [1:0]       res_ord
);

  typedef enum logic [3:0] {
    S_IDLE, S_NT1, S_NT2, S_DIVM, S_PMUL, S_PSQR, S_MAC, S_MUL, S_FIN
  } state_t;

  state_t         state;
  logic [3:0]     opr;
  logic [WIDTH-1:0] a, b, acc, y, base, pacc, t;
  logic [63:0]    e;
  logic [2:0]     rnd;
  logic           ok_r;
  logic           m_start, m_done;
  logic [WIDTH-1:0] mx, my, mp;

  mpa_mul #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .x(mx), .y(my),
    .done(m_done), .p(mp)
  );

  logic [WIDTH-1:0] two;
  assign two = WIDTH'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      m_start <= 1'b0;
    end else begin
      done    <= 1'b0;
      m_start <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          opr <= op; a <= a_in & mask; b <= b_in & mask; acc <= acc_in & mask;
          ok_r <= 1'b1; res_ord <= ORD_LESS; rnd <= '0; y <= WIDTH'(1);
          e <= e_in;
          case (op)
            OP_ADD: begin res <= (a_in + b_in) & mask; state <= S_FIN; end
            OP_SUB: begin res <= ((a_in & mask) - (b_in & mask)) & mask;
              state <= S_FIN; end
            OP_NEG: begin res <= (WIDTH'(0) - a_in) & mask; state <= S_FIN; end
            OP_INCR: begin res <= (a_in + WIDTH'(1)) & mask; state <= S_FIN; end
            OP_DECR: begin res <= ((a_in & mask) - WIDTH'(1)) & mask;
              state <= S_FIN; end
            OP_CMP: begin
              res <= '0;
              if ((a_in & mask) < (b_in & mask)) res_ord <= ORD_LESS;
              else if ((a_in & mask) == (b_in & mask)) res_ord <= ORD_EQUAL;
              else res_ord <= ORD_GREATER;
              state <= S_FIN;
            end
            OP_MUL, OP_ADDMUL, OP_SUBMUL: begin
              mx <= a_in & mask; my <= b_in & mask; m_start <= 1'b1;
              state <= S_MUL;
            end
            OP_INV, OP_DIV: begin
              t <= (op == OP_INV) ? (a_in & mask) : (b_in & mask);
              if (((op == OP_INV) ? a_in[0] : b_in[0]) == 1'b0) begin
                ok_r <= 1'b0; res <= '0; state <= S_FIN;
              end else begin
                mx <= (op == OP_INV) ? (a_in & mask) : (b_in & mask);
                my <= WIDTH'(1); m_start <= 1'b1; state <= S_NT1;
              end
            end
            OP_POW: begin
              pacc <= WIDTH'(1); base <= a_in & mask;
              if (e_in == 64'd0) begin
                res <= WIDTH'(1) & mask; state <= S_FIN;
              end else if (!e_in[63]) begin
                state <= S_PMUL;
              end else if (!a_in[0]) begin
                ok_r <= 1'b0; res <= '0; state <= S_FIN;
              end else begin
                e <= 64'd0 - e_in; t <= a_in & mask;
                mx <= a_in & mask; my <= WIDTH'(1); m_start <= 1'b1;
                state <= S_NT1;
              end
            end
            default: begin ok_r <= 1'b0; res <= '0; state <= S_FIN; end
          endcase
        end
        S_NT1: if (m_done) begin
          mx <= y; my <= two - mp; m_start <= 1'b1; state <= S_NT2;
        end
        S_NT2: if (m_done) begin
          y <= mp;
          if (rnd == 3'(NEWTON_ROUNDS - 1)) begin
            if (opr == OP_INV) begin res <= mp & mask; state <= S_FIN; end
            else if (opr == OP_DIV) begin
              mx <= a; my <= mp; m_start <= 1'b1; state <= S_DIVM;
            end else begin
              base <= mp; state <= S_PMUL;
            end
          end else begin
            rnd <= rnd + 3'd1; mx <= t; my <= mp; m_start <= 1'b1;
            state <= S_NT1;
          end
        end
        S_DIVM: if (m_done) begin res <= mp & mask; state <= S_FIN; end
        S_PMUL: begin
          if (e == 64'd0) begin
            res <= pacc & mask; state <= S_FIN;
          end else begin
            mx <= e[0] ? pacc : WIDTH'(1); my <= base; m_start <= 1'b1;
            state <= S_PSQR;
          end
        end
        S_PSQR: if (m_done) begin
          // accumulator only takes the product on a set exponent bit
          if (e[0]) pacc <= mp;
          mx <= base; my <= base; m_start <= 1'b1;
          state <= S_MAC;
        end
        S_MAC: if (m_done) begin
          base <= mp; e <= e >> 1; state <= S_PMUL;
        end
        S_MUL: if (m_done) begin
          case (opr)
            OP_ADDMUL: res <= (acc + mp) & mask;
            OP_SUBMUL: res <= (acc - mp) & mask;
            default:   res <= mp & mask;
          endcase
          state <= S_FIN;
        end
        S_FIN: begin
          res_ok <= ok_r; done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/mod_power_of_two_alu.sv
// Channel | dir | signals
// in      | in  | in_valid/in_ready, req_type, operand_a/b, accumulator_in, exponent
// out     | out | out_valid/out_ready, result_value, ok, order
// cfg     | in  | cfg_valid/cfg_ready, cfg_data (modulus_bits)
// One beat at a time. Each product on the shared multiplier runs launch,
// three 32x32 steps, done. pow handles one exponent bit per loop: a
// multiply, kept only on a set bit, then a square. A negative exponent
// inverts the base first and uses the 64-bit magnitude of the exponent.
// rst is synchronous; modulus_bits resets to 64. in_ready drops while an
// item is in flight or a result waits, so the next item is accepted only
// after the previous result is taken.
`include "assert_macros.svh"
module mod_power_of_two_alu
  import mpa_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           req_type,
  input  logic [WORD_BITS-1:0] operand_a,
  input  logic [WORD_BITS-1:0] operand_b,
  input  logic [WORD_BITS-1:0] accumulator_in,
  input  logic signed [63:0]   exponent,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] result_value,
  output logic                 ok,
  output logic [1:0]           order,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [6:0]           cfg_data
);

  logic [6:0]           modulus_bits;
  logic [WORD_BITS-1:0] mask;
  logic                 busy, done;
  logic [WORD_BITS-1:0] res;
  logic                 res_ok;
  logic [1:0]           res_ord;
  logic [6:0]           k;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy && !out_valid;

  // clamp k to 1..WORD_BITS
  always_comb begin
    k = modulus_bits;
    if (k == 7'd0) k = 7'd1;
    if (k > 7'(WORD_BITS)) k = 7'(WORD_BITS);
    mask = (k == 7'(WORD_BITS)) ? '1 : ((WORD_BITS'(1) << k) - WORD_BITS'(1));
  end

  mpa_core #(.WIDTH(WORD_BITS)) u_core (
    .clk(clk), .rst(rst), .start(in_valid && in_ready), .op(req_type),
    .mask(mask), .a_in(operand_a), .b_in(operand_b), .acc_in(accumulator_in),
    .e_in(exponent), .done(done), .res(res), .res_ok(res_ok), .res_ord(res_ord)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_bits <= 7'd64;
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) modulus_bits <= cfg_data;
      if (in_valid && in_ready) busy <= 1'b1;
      if (done) begin
        busy <= 1'b0; out_valid <= 1'b1;
        result_value <= res; ok <= res_ok; order <= res_ord;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, busy, !in_ready, "ready while busy")
  `ASSERT_IMPL(a_done_busy, clk, rst, done, busy, "done without item")
  `ASSERT_NEXT(a_fail_zero, clk, rst, done && !res_ok, result_value == '0, "fail not zero")

endmodule
